/* src/wsfp_pkg.sv */
// ----------------------------------------------------------------------------
// wsfp_pkg : shared types and codes for the WebSocket frame parser
// Event codes, length codes and the result word passed from core to top.
// ----------------------------------------------------------------------------
package wsfp_pkg;

	localparam int EventW  = 3;
	localparam int LengthW = 64;
	localparam int KeyW    = 32;

	// event codes
	localparam logic [EventW-1:0] EV_HEADER  = 3'd0;
	localparam logic [EventW-1:0] EV_PAYLOAD = 3'd1;
	localparam logic [EventW-1:0] EV_ERROR   = 3'd2;
	localparam logic [EventW-1:0] EV_IGNORED = 3'd3;
	localparam logic [EventW-1:0] EV_RESET   = 3'd4;

	// seven-bit length codes that announce an extended length
	localparam logic [6:0] LEN_CODE_EXT16 = 7'd126;
	localparam logic [6:0] LEN_CODE_EXT64 = 7'd127;

	// extension sizes in bytes
	localparam logic [3:0] EXT16_BYTES = 4'd2;
	localparam logic [3:0] EXT64_BYTES = 4'd8;
	localparam logic [3:0] KEY_BYTES   = 4'd4;

	typedef struct packed {
		logic [EventW-1:0]  event_res;
		logic [7:0]         payload_byte;
		logic               frame_end;
		logic               final_flag;
		logic [3:0]         opcode;
		logic               masked;
		logic [KeyW-1:0]    mask_key;
		logic [LengthW-1:0] frame_length;
		logic [LengthW-1:0] payload_offset;
	} wsfp_result_t;

endpackage

/* src/wsfp_core.sv */
// ----------------------------------------------------------------------------
// wsfp_core : header state machine and per-word result logic
// Holds the parse state; computes one result per word and advances on step.
// ----------------------------------------------------------------------------
module wsfp_core (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 step,
	input  logic                 action,
	input  logic [7:0]           in_byte,
	output wsfp_pkg::wsfp_result_t result
);

	localparam logic [2:0] PH_START   = 3'd0;
	localparam logic [2:0] PH_BYTE2   = 3'd1;
	localparam logic [2:0] PH_LEN     = 3'd2;
	localparam logic [2:0] PH_MASK    = 3'd3;
	localparam logic [2:0] PH_PAYLOAD = 3'd4;
	localparam logic [2:0] PH_ERROR   = 3'd5;

	logic [2:0]                     phase_q, phase_n;
	logic [7:0]                     first_hdr_q, first_hdr_n;
	logic                           mask_pres_q, mask_pres_n;
	logic [3:0]                     bytes_left_q, bytes_left_n;
	logic [wsfp_pkg::LengthW-1:0]   exp_len_q, exp_len_n;
	logic [wsfp_pkg::LengthW-1:0]   offset_q, offset_n, offset_inc;
	logic [wsfp_pkg::KeyW-1:0]      mask_word_q, mask_word_n;
	logic                           len_known, fill_hdr, done, hdr_err;

	assign offset_inc = offset_q + {{(wsfp_pkg::LengthW-1){1'b0}}, 1'b1};
	assign hdr_err    = (in_byte[6:4] != 3'd0) || in_byte[2] || (in_byte[1:0] == 2'b11);

	always_comb begin
		phase_n      = phase_q;
		first_hdr_n  = first_hdr_q;
		mask_pres_n  = mask_pres_q;
		bytes_left_n = bytes_left_q;
		exp_len_n    = exp_len_q;
		offset_n     = offset_q;
		mask_word_n  = mask_word_q;
		len_known    = 1'b0;
		fill_hdr     = 1'b0;
		done         = 1'b0;
		result       = '0;

		if (action) begin
			phase_n          = PH_START;
			first_hdr_n      = 8'd0;
			mask_pres_n      = 1'b0;
			bytes_left_n     = 4'd0;
			exp_len_n        = '0;
			offset_n         = '0;
			mask_word_n      = '0;
			result.event_res = wsfp_pkg::EV_RESET;
		end else begin
			unique case (phase_q)
				PH_START: begin
					first_hdr_n  = in_byte;
					mask_pres_n  = 1'b0;
					bytes_left_n = 4'd0;
					fill_hdr     = 1'b1;
					if (hdr_err) begin
						phase_n          = PH_ERROR;
						result.event_res = wsfp_pkg::EV_ERROR;
					end else begin
						phase_n          = PH_BYTE2;
						result.event_res = wsfp_pkg::EV_HEADER;
					end
				end
				PH_BYTE2: begin
					mask_pres_n      = in_byte[7];
					fill_hdr         = 1'b1;
					result.event_res = wsfp_pkg::EV_HEADER;
					if (in_byte[6:0] == wsfp_pkg::LEN_CODE_EXT16) begin
						bytes_left_n = wsfp_pkg::EXT16_BYTES;
						phase_n      = PH_LEN;
					end else if (in_byte[6:0] == wsfp_pkg::LEN_CODE_EXT64) begin
						bytes_left_n = wsfp_pkg::EXT64_BYTES;
						phase_n      = PH_LEN;
					end else begin
						bytes_left_n = 4'd0;
						exp_len_n    = {{(wsfp_pkg::LengthW-7){1'b0}}, in_byte[6:0]};
						len_known    = 1'b1;
					end
				end
				PH_LEN: begin
					exp_len_n        = {exp_len_q[wsfp_pkg::LengthW-9:0], in_byte};
					fill_hdr         = 1'b1;
					result.event_res = wsfp_pkg::EV_HEADER;
					if (bytes_left_q <= 4'd1) begin
						bytes_left_n = 4'd0;
						len_known    = 1'b1;
					end else begin
						bytes_left_n = bytes_left_q - 4'd1;
					end
				end
				PH_MASK: begin
					mask_word_n      = {mask_word_q[wsfp_pkg::KeyW-9:0], in_byte};
					fill_hdr         = 1'b1;
					result.event_res = wsfp_pkg::EV_HEADER;
					if (bytes_left_q <= 4'd1) begin
						bytes_left_n = 4'd0;
						if (exp_len_q == '0) begin
							done = 1'b1;
						end else begin
							phase_n = PH_PAYLOAD;
						end
					end else begin
						bytes_left_n = bytes_left_q - 4'd1;
					end
				end
				PH_PAYLOAD: begin
					fill_hdr              = 1'b1;
					result.event_res      = wsfp_pkg::EV_PAYLOAD;
					result.payload_byte   = in_byte;
					result.payload_offset = offset_q;
					offset_n              = offset_inc;
					if (offset_inc >= exp_len_q) begin
						done = 1'b1;
					end
				end
				default: begin
					// error phase and unused codes: drop the word
					result.event_res = wsfp_pkg::EV_IGNORED;
				end
			endcase
		end

		// length settled: go on to the key, the payload, or close an empty frame
		if (len_known) begin
			if (mask_pres_n) begin
				bytes_left_n = wsfp_pkg::KEY_BYTES;
				phase_n      = PH_MASK;
			end else if (exp_len_n == '0) begin
				done = 1'b1;
			end else begin
				phase_n = PH_PAYLOAD;
			end
		end

		if (fill_hdr) begin
			result.final_flag   = first_hdr_n[7];
			result.opcode       = first_hdr_n[3:0];
			result.masked       = mask_pres_n;
			result.mask_key     = mask_word_n;
			result.frame_length = exp_len_n;
		end

		if (done) begin
			result.frame_end = 1'b1;
			phase_n          = PH_START;
			exp_len_n        = '0;
			offset_n         = '0;
			mask_word_n      = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= PH_START;
			first_hdr_q  <= 8'd0;
			mask_pres_q  <= 1'b0;
			bytes_left_q <= 4'd0;
			exp_len_q    <= '0;
			offset_q     <= '0;
			mask_word_q  <= '0;
		end else if (step) begin
			phase_q      <= phase_n;
			first_hdr_q  <= first_hdr_n;
			mask_pres_q  <= mask_pres_n;
			bytes_left_q <= bytes_left_n;
			exp_len_q    <= exp_len_n;
			offset_q     <= offset_n;
			mask_word_q  <= mask_word_n;
		end
	end

endmodule

/* src/websocket_frame_parser_top.sv */
// ----------------------------------------------------------------------------
// websocket_frame_parser_top : streaming WebSocket frame header parser
// Throughput: one word per cycle while m_tready holds; input register, state update, result register.
// Reset: arst_n clears both stages and returns the parser to frame start.
// A reset word on tuser returns the parse state to frame start in-band and yields a reset-done result.
// ----------------------------------------------------------------------------
module websocket_frame_parser_top (
	input  logic         clk,
	input  logic         arst_n,
	// input stream
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [7:0]   s_tdata,   // [7:0] in_byte
	input  logic         s_tuser,   // [0] action (1 = reset parser)
	// result stream
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [175:0] m_tdata,   // [7:0] payload_byte, [8] final_flag,
	                                // [12:9] opcode, [13] masked,
	                                // [45:14] mask_key, [109:46] frame_length,
	                                // [173:110] payload_offset, [175:174] zero
	output logic [2:0]   m_tuser,   // [2:0] event_res
	output logic         m_tlast    // frame_end
);

	// stage 1: captured input word
	logic       valid_s1;
	logic       action_s1;
	logic [7:0] byte_s1;

	// stage 2: registered result
	logic                   valid_s2;
	wsfp_pkg::wsfp_result_t res_s2;

	wsfp_pkg::wsfp_result_t res_comb;
	logic                   s2_free;
	logic                   advance;

	// the result register frees when empty or being taken this cycle
	assign s2_free  = !valid_s2 || m_tready;
	// move stage 1 into stage 2; the parse state steps with it
	assign advance  = valid_s1 && s2_free;
	// take a new word whenever stage 1 is empty or draining
	assign s_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	// payload of stage 1 needs no reset; hold it while stalled
	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			action_s1 <= s_tuser;
			byte_s1   <= s_tdata;
		end
	end

	wsfp_core u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (advance),
		.action  (action_s1),
		.in_byte (byte_s1),
		.result  (res_comb)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (s2_free) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_s2 <= res_comb;
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tuser  = res_s2.event_res;
	assign m_tlast  = res_s2.frame_end;
	assign m_tdata  = {2'b00,
	                   res_s2.payload_offset,
	                   res_s2.frame_length,
	                   res_s2.mask_key,
	                   res_s2.masked,
	                   res_s2.opcode,
	                   res_s2.final_flag,
	                   res_s2.payload_byte};

endmodule
